>>> rtl/dsm_pkg.sv
// Shared constants, mode codes and controller/datapath types for the speed controller.
package dsm_pkg;

   // Field widths.
   localparam int DIST_W = 10;
   localparam int DUR_W  = 16;
   localparam int TIME_W = 32;
   localparam int SPD_W  = 8;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 2;

   // Divider sizing: the quotient stays below 100, so seven bits cover it.
   localparam int QUOT_W = 7;
   localparam int PROD_W = 17;
   localparam int DIVR_W = DIST_W + QUOT_W - 1;
   localparam int CNT_W  = 3;
   localparam logic [CNT_W-1:0] DIV_FIRST = CNT_W'(QUOT_W - 1);
   localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);

   // Operating modes.
   localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STOPPING  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REVERSING = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SLOW_FWD  = 2'd3;

   // Speed commands in percent.
   localparam logic signed [SPD_W-1:0] SPEED_STOP    = 8'sd0;
   localparam logic signed [SPD_W-1:0] SPEED_REVERSE = -8'sd20;
   localparam logic signed [SPD_W-1:0] SPEED_CREEP   = 8'sd20;
   localparam logic signed [SPD_W-1:0] SPEED_FULL    = 8'sd100;

   // Register indexes.
   localparam logic [IDX_W-1:0] CSR_MIN_DIST = 2'd0;
   localparam logic [IDX_W-1:0] CSR_MAX_DIST = 2'd1;
   localparam logic [IDX_W-1:0] CSR_STOP_MS  = 2'd2;
   localparam logic [IDX_W-1:0] CSR_REV_MS   = 2'd3;

   // Reset values of the registers.
   localparam logic [DIST_W-1:0] RST_MIN_DIST = 10'd5;
   localparam logic [DIST_W-1:0] RST_MAX_DIST = 10'd60;
   localparam logic [DUR_W-1:0]  RST_STOP_MS  = 16'd500;
   localparam logic [DUR_W-1:0]  RST_REV_MS   = 16'd200;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

>>> rtl/dsm_if.sv
// Handshake channel interfaces for updates, results and register writes.

// Update channel: one distance reading and its timestamp per item.
interface dsm_req_if;
   logic                            valid;
   logic                            ready;
   logic [dsm_pkg::DIST_W-1:0]      distance_cm;
   logic [dsm_pkg::TIME_W-1:0]      now_ms;

   modport source (output valid, output distance_cm, output now_ms, input ready);
   modport sink   (input valid, input distance_cm, input now_ms, output ready);
endinterface

// Result channel: speed command and mode after the update.
interface dsm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [dsm_pkg::SPD_W-1:0] speed_pct;
   logic [dsm_pkg::MODE_W-1:0]      mode_out;

   modport source (output valid, output speed_pct, output mode_out, input ready);
   modport sink   (input valid, input speed_pct, input mode_out, output ready);
endinterface

// Register write channel.
interface dsm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dsm_pkg::IDX_W-1:0]       reg_index;
   logic [dsm_pkg::DUR_W-1:0]       data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink   (input valid, input reg_index, input data, output ready);
endinterface

>>> rtl/dsm_ctrl.sv
// Sequencing state machine and result valid flag of the speed controller.
module dsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dsm_pkg::cmd_type    cmd,
   input  dsm_pkg::status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state, datapath commands and result valid flag.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.need_div ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/dsm_dp.sv
// Datapath: registers, mode update, speed scaling and the bit-serial divider.
module dsm_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dsm_pkg::cmd_type                    cmd,
   output dsm_pkg::status_type                 status,
   input  logic [dsm_pkg::DIST_W-1:0]          req_distance_cm,
   input  logic [dsm_pkg::TIME_W-1:0]          req_now_ms,
   input  logic                                csr_write,
   input  logic [dsm_pkg::IDX_W-1:0]           csr_reg_index,
   input  logic [dsm_pkg::DUR_W-1:0]           csr_data,
   output logic signed [dsm_pkg::SPD_W-1:0]    rsp_speed_pct,
   output logic [dsm_pkg::MODE_W-1:0]          rsp_mode_out
);

   // Configuration registers.
   logic [dsm_pkg::DIST_W-1:0] min_ff, min_in;
   logic [dsm_pkg::DIST_W-1:0] max_ff, max_in;
   logic [dsm_pkg::DUR_W-1:0]  stop_ff, stop_in;
   logic [dsm_pkg::DUR_W-1:0]  rev_ff, rev_in;

   // Mode state.
   logic [dsm_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [dsm_pkg::TIME_W-1:0] start_ff, start_in;

   // Captured item and working registers.
   logic [dsm_pkg::DIST_W-1:0]       dist_ff, dist_in;
   logic [dsm_pkg::TIME_W-1:0]       now_ff, now_in;
   logic signed [dsm_pkg::SPD_W-1:0] speed_ff, speed_in;
   logic [dsm_pkg::PROD_W-1:0]       rem_ff, rem_in;
   logic [dsm_pkg::DIVR_W-1:0]       divr_ff, divr_in;
   logic [dsm_pkg::QUOT_W-1:0]       quot_ff, quot_in;
   logic [dsm_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   // Output register.
   logic signed [dsm_pkg::SPD_W-1:0] out_speed_ff, out_speed_in;
   logic [dsm_pkg::MODE_W-1:0]       out_mode_ff, out_mode_in;

   logic [dsm_pkg::TIME_W-1:0]   elapsed;
   logic                         far;
   logic [dsm_pkg::DIST_W-1:0]   diff;
   logic [dsm_pkg::DIST_W-1:0]   span;
   logic [dsm_pkg::PROD_W-1:0]   prod;
   logic [dsm_pkg::PROD_W:0]     trial;
   logic [dsm_pkg::QUOT_W-1:0]   quot_next;

   assign elapsed = now_ff - start_ff;
   assign far     = (dist_ff >= max_ff);
   assign diff    = dist_ff - min_ff;
   assign span    = max_ff - min_ff;
   assign prod    = dsm_pkg::PROD_W'(diff) * dsm_pkg::PCT_SCALE;

   // A near reading strictly between the limits needs the division.
   assign status.need_div = !far && (dist_ff != '0) && (dist_ff > min_ff) && (max_ff > min_ff);
   assign status.div_last = (cnt_ff == '0);

   // One restoring step per cycle, divisor shifted right each step.
   assign trial     = {1'b0, rem_ff} - (dsm_pkg::PROD_W + 1)'(divr_ff);
   assign quot_next = {quot_ff[dsm_pkg::QUOT_W-2:0], !trial[dsm_pkg::PROD_W]};

   assign rsp_speed_pct = out_speed_ff;
   assign rsp_mode_out  = out_mode_ff;

   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      stop_in      = stop_ff;
      rev_in       = rev_ff;
      mode_in      = mode_ff;
      start_in     = start_ff;
      dist_in      = dist_ff;
      now_in       = now_ff;
      speed_in     = speed_ff;
      rem_in       = rem_ff;
      divr_in      = divr_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      out_speed_in = out_speed_ff;
      out_mode_in  = out_mode_ff;

      // Register writes.
      if (csr_write) begin
         unique case (csr_reg_index)
            dsm_pkg::CSR_MIN_DIST: min_in  = csr_data[dsm_pkg::DIST_W-1:0];
            dsm_pkg::CSR_MAX_DIST: max_in  = csr_data[dsm_pkg::DIST_W-1:0];
            dsm_pkg::CSR_STOP_MS:  stop_in = csr_data;
            dsm_pkg::CSR_REV_MS:   rev_in  = csr_data;
            default: ;
         endcase
      end

      // Capture an accepted item.
      if (cmd.capture) begin
         dist_in = req_distance_cm;
         now_in  = req_now_ms;
      end

      // Mode update and the speeds that need no division.
      if (cmd.eval) begin
         rem_in  = prod;
         divr_in = {span, {(dsm_pkg::QUOT_W-1){1'b0}}};
         quot_in = '0;
         cnt_in  = dsm_pkg::DIV_FIRST;
         if (far) begin
            case (mode_ff)
               dsm_pkg::MODE_NORMAL: begin
                  speed_in = dsm_pkg::SPEED_STOP;
                  mode_in  = dsm_pkg::MODE_STOPPING;
                  start_in = now_ff;
               end
               dsm_pkg::MODE_STOPPING: begin
                  speed_in = dsm_pkg::SPEED_STOP;
                  if (elapsed >= dsm_pkg::TIME_W'(stop_ff)) begin
                     mode_in  = dsm_pkg::MODE_REVERSING;
                     start_in = now_ff;
                  end
               end
               dsm_pkg::MODE_REVERSING: begin
                  speed_in = dsm_pkg::SPEED_REVERSE;
                  if (elapsed >= dsm_pkg::TIME_W'(rev_ff)) begin
                     mode_in  = dsm_pkg::MODE_SLOW_FWD;
                     start_in = now_ff;
                  end
               end
               default: speed_in = dsm_pkg::SPEED_CREEP;
            endcase
         end else begin
            mode_in  = dsm_pkg::MODE_NORMAL;
            start_in = now_ff;
            if (dist_ff == '0) begin
               speed_in = dsm_pkg::SPEED_FULL;
            end else begin
               speed_in = dsm_pkg::SPEED_STOP;
            end
         end
      end

      // Division step; the last one writes the speed, rounded down to even.
      if (cmd.div_step) begin
         if (!trial[dsm_pkg::PROD_W]) begin
            rem_in = trial[dsm_pkg::PROD_W-1:0];
         end
         quot_in = quot_next;
         divr_in = divr_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            speed_in = {1'b0, quot_next[dsm_pkg::QUOT_W-1:1], 1'b0};
         end
      end

      // Result register.
      if (cmd.load_out) begin
         out_speed_in = speed_ff;
         out_mode_in  = mode_ff;
      end
   end

   // State and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= dsm_pkg::RST_MIN_DIST;
         max_ff   <= dsm_pkg::RST_MAX_DIST;
         stop_ff  <= dsm_pkg::RST_STOP_MS;
         rev_ff   <= dsm_pkg::RST_REV_MS;
         mode_ff  <= dsm_pkg::MODE_NORMAL;
         start_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         stop_ff  <= stop_in;
         rev_ff   <= rev_in;
         mode_ff  <= mode_in;
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      now_ff       <= now_in;
      speed_ff     <= speed_in;
      rem_ff       <= rem_in;
      divr_ff      <= divr_in;
      quot_ff      <= quot_in;
      out_speed_ff <= out_speed_in;
      out_mode_ff  <= out_mode_in;
   end

endmodule

>>> rtl/distance_speed_maneuver_fsm.sv
// Top level of the distance-to-speed controller with timed obstacle maneuver.
//
//   Channel   Direction  Carries
//   req_bus   in         distance_cm, now_ms
//   rsp_bus   out        speed_pct, mode_out
//   csr_bus   in         reg_index, data (register write)
//
// An item is captured and evaluated, and for the near-range speed it then passes
// through the 7-step bit-serial divider before its result is loaded.
// Reset (synchronous) restores the register defaults and normal mode.
// A finished result sits in the output register while the next item is taken;
// a stalled result channel holds the following item before its result is loaded.
// Register writes are always taken; csr ready is held high.
module distance_speed_maneuver_fsm (
   input  logic      clock,
   input  logic      reset,
   dsm_req_if.sink   req_bus,
   dsm_rsp_if.source rsp_bus,
   dsm_csr_if.sink   csr_bus
);

   dsm_pkg::cmd_type    cmd;
   dsm_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   // Sequencer.
   dsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   dsm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_distance_cm (req_bus.distance_cm),
      .req_now_ms      (req_bus.now_ms),
      .csr_write       (csr_bus.valid),
      .csr_reg_index   (csr_bus.reg_index),
      .csr_data        (csr_bus.data),
      .rsp_speed_pct   (rsp_bus.speed_pct),
      .rsp_mode_out    (rsp_bus.mode_out)
   );

endmodule
